// ===== src/audio_silence_trim_bounds_assert.svh =====
// Assertion macros used by the RTL. Clocked on i_clk, off while i_rst_n is low.
`ifndef AUDIO_SILENCE_TRIM_BOUNDS_ASSERT_SVH
`define AUDIO_SILENCE_TRIM_BOUNDS_ASSERT_SVH

// Property must hold at every clock edge.
`define ASB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// When cond holds, expect holds on the next edge.
`define ASB_ASSERT_NEXT(label, cond, expect_prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (expect_prop)) else $error(msg);

`endif

// ===== src/asb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package asb_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int INDEX_BITS   = 32;
    localparam int THRESH_BITS  = 24;
    localparam int CFG_BITS     = 32;
    localparam int OUT_BITS     = 32;
    localparam int CFG_IDX_BITS = 2;

    localparam int MAG_BITS  = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
    // Bounds arithmetic: index or margin, plus one, plus margin.
    localparam int CALC_BITS = ((INDEX_BITS > CFG_BITS) ? INDEX_BITS : CFG_BITS) + 2;

    localparam int S_TDATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = 2 * OUT_BITS;

    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_THRESHOLD   = 2'd0,
        CFG_MARGIN      = 2'd1,
        CFG_MIN_SILENCE = 2'd2
    } t_cfg_idx;

    // One classified frame, front to back.
    typedef struct packed {
        logic                  loud;
        logic                  last_frame;
        logic [INDEX_BITS-1:0] idx;
    } t_frame_info;

    // Clip summary handed to the bounds pipeline on the final frame.
    typedef struct packed {
        logic                  found;
        logic [INDEX_BITS-1:0] first_idx;
        logic [INDEX_BITS-1:0] last_idx;
        logic [INDEX_BITS-1:0] final_idx;
    } t_clip_sum;

endpackage
`default_nettype wire

// ===== src/asb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module asb_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [asb_pkg::SAMPLE_BITS-1:0] i_left,
    input  wire logic [asb_pkg::SAMPLE_BITS-1:0] i_right,
    input  wire logic                           i_readable,
    input  wire logic                           i_last,
    input  wire logic [asb_pkg::THRESH_BITS-1:0] i_threshold,
    input  wire logic                           i_full,
    output logic                                o_push,
    output asb_pkg::t_frame_info                o_info
);
    import asb_pkg::*;

    logic [INDEX_BITS-1:0]  r_count;
    logic [INDEX_BITS-1:0]  n_count;
    logic [SAMPLE_BITS-1:0] mag_l;
    logic [SAMPLE_BITS-1:0] mag_r;
    logic [MAG_BITS-1:0]    mag_max;
    logic [MAG_BITS-1:0]    thr_ext;

    // Two's complement magnitude; most negative value maps to the sign weight.
    assign mag_l = i_left[SAMPLE_BITS-1]  ? (~i_left + 1'b1)  : i_left;
    assign mag_r = i_right[SAMPLE_BITS-1] ? (~i_right + 1'b1) : i_right;

    assign mag_max = (mag_l > mag_r) ? MAG_BITS'(mag_l) : MAG_BITS'(mag_r);
    assign thr_ext = MAG_BITS'(i_threshold);

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    assign o_info.loud       = i_readable && (mag_max >= thr_ext);
    assign o_info.last_frame = i_last;
    assign o_info.idx        = r_count;

    always_comb begin
        n_count = r_count;
        if (o_push) begin
            if (i_last) begin
                n_count = '0;
            end else if (r_count != {INDEX_BITS{1'b1}}) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

// ===== src/asb_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module asb_fifo (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire asb_pkg::t_frame_info i_data,
    output logic                      o_full,
    input  wire logic                 i_pop,
    output logic                      o_valid,
    output asb_pkg::t_frame_info      o_data
);
    import asb_pkg::*;

    t_frame_info               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0]  r_wr_ptr;
    logic [FIFO_PTR_BITS-1:0]  r_rd_ptr;
    logic [FIFO_CNT_BITS-1:0]  r_count;

    assign o_full  = (r_count == FIFO_CNT_BITS'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`include "audio_silence_trim_bounds_assert.svh"

    `ASB_ASSERT(a_fifo_no_overflow, !(i_push && o_full), "asb_fifo: push while full")
    `ASB_ASSERT(a_fifo_no_underflow, !(i_pop && !o_valid), "asb_fifo: pop while empty")
    `ASB_ASSERT(a_fifo_count_range, r_count <= FIFO_CNT_BITS'(FIFO_DEPTH), "asb_fifo: bad fill")
    `ASB_ASSERT_NEXT(a_fifo_count_up, i_push && !i_pop,
        r_count == $past(r_count) + 1'b1, "asb_fifo: fill not incremented")

endmodule
`default_nettype wire

// ===== src/asb_track.sv =====
`timescale 1ns / 1ps
`default_nettype none
module asb_track (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire asb_pkg::t_frame_info i_info,
    output logic                      o_pop,
    output logic                      o_sum_valid,
    input  wire logic                 i_sum_ready,
    output asb_pkg::t_clip_sum        o_sum
);
    import asb_pkg::*;

    logic                  r_any;
    logic [INDEX_BITS-1:0] r_first;
    logic [INDEX_BITS-1:0] r_last;
    logic                  n_any;
    logic [INDEX_BITS-1:0] n_first;
    logic [INDEX_BITS-1:0] n_last;

    // A final frame waits until the bounds pipeline can take its summary.
    assign o_pop       = i_valid && (!i_info.last_frame || i_sum_ready);
    assign o_sum_valid = i_valid && i_info.last_frame;

    always_comb begin
        n_any   = r_any;
        n_first = r_first;
        n_last  = r_last;
        if (i_info.loud) begin
            if (!r_any) begin
                n_first = i_info.idx;
            end
            n_last = i_info.idx;
            n_any  = 1'b1;
        end
    end

    assign o_sum.found     = n_any;
    assign o_sum.first_idx = n_first;
    assign o_sum.last_idx  = n_last;
    assign o_sum.final_idx = i_info.idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any   <= 1'b0;
            r_first <= '0;
            r_last  <= '0;
        end else if (o_pop) begin
            if (i_info.last_frame) begin
                r_any   <= 1'b0;
                r_first <= '0;
                r_last  <= '0;
            end else begin
                r_any   <= n_any;
                r_first <= n_first;
                r_last  <= n_last;
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/asb_bounds.sv =====
`timescale 1ns / 1ps
`default_nettype none
module asb_bounds (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire asb_pkg::t_clip_sum          i_sum,
    input  wire logic [asb_pkg::CFG_BITS-1:0] i_margin,
    input  wire logic [asb_pkg::CFG_BITS-1:0] i_min_sil,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic                             o_found,
    output logic [asb_pkg::OUT_BITS-1:0]     o_start,
    output logic [asb_pkg::OUT_BITS-1:0]     o_end
);
    import asb_pkg::*;

    logic [CALC_BITS-1:0] first_x;
    logic [CALC_BITS-1:0] last_x;
    logic [CALC_BITS-1:0] margin_x;
    logic [CALC_BITS-1:0] min_x;

    // stage 1: raw start and end
    logic                 r_s1_valid;
    logic                 r_s1_found;
    logic [CALC_BITS-1:0] r_s1_start;
    logic [CALC_BITS-1:0] r_s1_end;
    logic [CALC_BITS-1:0] r_s1_total;
    // stage 2: end clamped to clip, start edge check
    logic                 r_s2_valid;
    logic                 r_s2_found;
    logic [CALC_BITS-1:0] r_s2_start;
    logic [CALC_BITS-1:0] r_s2_end;
    logic [CALC_BITS-1:0] r_s2_total;
    // output register
    logic                 r_o_valid;
    logic                 r_o_found;
    logic [OUT_BITS-1:0]  r_o_start;
    logic [OUT_BITS-1:0]  r_o_end;

    logic                 rdy_o;
    logic                 rdy_s2;
    logic [CALC_BITS-1:0] tail_gap;
    logic [CALC_BITS-1:0] end_fin;

    assign first_x  = CALC_BITS'(i_sum.first_idx);
    assign last_x   = CALC_BITS'(i_sum.last_idx);
    assign margin_x = CALC_BITS'(i_margin);
    assign min_x    = CALC_BITS'(i_min_sil);

    assign rdy_o   = !r_o_valid || i_ready;
    assign rdy_s2  = !r_s2_valid || rdy_o;
    assign o_ready = !r_s1_valid || rdy_s2;

    assign tail_gap = r_s2_total - r_s2_end;
    assign end_fin  = (tail_gap < min_x) ? r_s2_total : r_s2_end;

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_s1_found <= i_sum.found;
            r_s1_start <= (first_x >= margin_x) ? (first_x - margin_x) : '0;
            r_s1_end   <= last_x + margin_x + 1'b1;
            r_s1_total <= CALC_BITS'(i_sum.final_idx) + 1'b1;
        end
        if (rdy_s2) begin
            r_s2_found <= r_s1_found;
            r_s2_start <= (r_s1_start < min_x) ? '0 : r_s1_start;
            r_s2_end   <= (r_s1_end > r_s1_total) ? r_s1_total : r_s1_end;
            r_s2_total <= r_s1_total;
        end
        if (rdy_o) begin
            r_o_found <= r_s2_found;
            r_o_start <= r_s2_found ? OUT_BITS'(r_s2_start) : '0;
            r_o_end   <= r_s2_found ? OUT_BITS'(end_fin) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (rdy_s2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (rdy_o) begin
                r_o_valid <= r_s2_valid;
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_found = r_o_found;
    assign o_start = r_o_start;
    assign o_end   = r_o_end;

endmodule
`default_nettype wire

// ===== src/audio_silence_trim_bounds.sv =====
// Silence trim bounds finder. Stereo frames of a clip stream in on the slave side, one
// transfer per clock while the four-entry queue is not full; tlast marks the final frame
// of the clip and tuser says the frame was readable (an unreadable frame is counted but
// never loud). A frame is loud when max(|left|, |right|) >= threshold. On the final frame
// one result leaves on the master side: tuser = sound found, and in tdata the first frame
// to keep and the exclusive end frame, both widened by the margin, clamped to the clip,
// and left untrimmed at an edge whose silence is shorter than the minimum; a silent clip
// gives zeros. Non-final frames give nothing. The front classifies and numbers each frame
// in its accept cycle, a four-entry queue decouples it from the tracker, and a
// three-register bounds pipeline (stage 1, stage 2, output register) follows. Frame indices
// saturate at all ones for very long clips. Registers (index: 0 threshold, 1 margin,
// 2 minimum silence) must be written only while the block is idle; it does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module audio_silence_trim_bounds (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // slave side
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // [SAMPLE_BITS-1:0] left_sample, [2*SAMPLE_BITS-1:SAMPLE_BITS] right_sample, zero pad
    input  wire logic [asb_pkg::S_TDATA_BITS-1:0] i_s_tdata,
    // [0] frame_readable
    input  wire logic                             i_s_tuser,
    input  wire logic                             i_s_tlast,
    // master side
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // [31:0] start_frame, [63:32] end_frame
    output logic [asb_pkg::M_TDATA_BITS-1:0]      o_m_tdata,
    // [0] sound_found
    output logic                                  o_m_tuser,
    // configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic [asb_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [asb_pkg::CFG_BITS-1:0]     i_cfg_wdata
);
    import asb_pkg::*;

    logic [THRESH_BITS-1:0] r_threshold;
    logic [CFG_BITS-1:0]    r_margin;
    logic [CFG_BITS-1:0]    r_min_sil;

    logic        fifo_full;
    logic        fifo_push;
    logic        fifo_pop;
    logic        fifo_valid;
    t_frame_info push_info;
    t_frame_info head_info;

    logic        sum_valid;
    logic        sum_ready;
    t_clip_sum   clip_sum;

    logic [OUT_BITS-1:0] res_start;
    logic [OUT_BITS-1:0] res_end;

    // Config registers; unknown indices are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_margin    <= '0;
            r_min_sil   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESHOLD:   r_threshold <= i_cfg_wdata[THRESH_BITS-1:0];
                CFG_MARGIN:      r_margin    <= i_cfg_wdata;
                CFG_MIN_SILENCE: r_min_sil   <= i_cfg_wdata;
                default:         ;
            endcase
        end
    end

    asb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_left      (i_s_tdata[SAMPLE_BITS-1:0]),
        .i_right     (i_s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .i_readable  (i_s_tuser),
        .i_last      (i_s_tlast),
        .i_threshold (r_threshold),
        .i_full      (fifo_full),
        .o_push      (fifo_push),
        .o_info      (push_info)
    );

    asb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_data  (push_info),
        .o_full  (fifo_full),
        .i_pop   (fifo_pop),
        .o_valid (fifo_valid),
        .o_data  (head_info)
    );

    asb_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (fifo_valid),
        .i_info      (head_info),
        .o_pop       (fifo_pop),
        .o_sum_valid (sum_valid),
        .i_sum_ready (sum_ready),
        .o_sum       (clip_sum)
    );

    asb_bounds u_bounds (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (sum_valid),
        .o_ready   (sum_ready),
        .i_sum     (clip_sum),
        .i_margin  (r_margin),
        .i_min_sil (r_min_sil),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_found   (o_m_tuser),
        .o_start   (res_start),
        .o_end     (res_end)
    );

    assign o_m_tdata = {res_end, res_start};

endmodule
`default_nettype wire
